FILE: hdl/cor_pkg.sv
// shared types and constants for the circle outline rasterizer
`timescale 1ns / 1ps

package cor_pkg;

  // action codes carried on in_tuser
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam int CENTER_W = 13;
  localparam int RADIUS_W = 10;
  localparam int COLOR_W  = 32;
  localparam int OFFX_W   = 11;
  localparam int OFFS_W   = 12;
  localparam int DEC_W    = 24;
  localparam int COORD_W  = 14;
  localparam int PIXIDX_W = 20;
  localparam int OCT_W    = 3;

  localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one step's worth of work handed from front to back
  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [OFFS_W-1:0]   ox;
    logic [OFFS_W-1:0]   oy;
    logic [COLOR_W-1:0]  color;
    logic                done;
  } step_t;

endpackage

FILE: hdl/cor_front.sv
// front end: accepts beats, runs the midpoint decision and issues step records
`timescale 1ns / 1ps

module cor_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cor_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output cor_pkg::step_t                    q_data
);

  logic [cor_pkg::OFFX_W-1:0]          x_r;
  logic signed [cor_pkg::OFFS_W-1:0]   y_r;
  logic signed [cor_pkg::DEC_W-1:0]    d_r;
  logic [cor_pkg::CENTER_W-1:0]        cx_r;
  logic [cor_pkg::CENTER_W-1:0]        cy_r;
  logic [cor_pkg::COLOR_W-1:0]         color_r;
  logic                                active_r;

  logic [cor_pkg::CENTER_W-1:0]        in_cx;
  logic [cor_pkg::CENTER_W-1:0]        in_cy;
  logic [cor_pkg::RADIUS_W-1:0]        in_radius;
  logic [cor_pkg::COLOR_W-1:0]         in_color;
  logic                                accept;
  logic                                is_start;
  logic                                dec_pos;
  logic [cor_pkg::OFFX_W-1:0]          x_inc;
  logic signed [cor_pkg::OFFS_W-1:0]   y_step;
  logic signed [cor_pkg::OFFS_W:0]     diff;
  logic signed [cor_pkg::DEC_W-1:0]    d_step;
  logic                                done_step;

  assign in_cx     = in_tdata[12:0];
  assign in_cy     = in_tdata[25:13];
  assign in_radius = in_tdata[35:26];
  assign in_color  = in_tdata[67:36];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_start  = (in_tuser == cor_pkg::ACT_START);

  assign dec_pos = (d_r > 0);
  assign x_inc   = x_r + 11'd1;
  assign y_step  = dec_pos ? (y_r - 12'sd1) : y_r;
  assign diff    = $signed({2'b00, x_inc}) - $signed({y_step[cor_pkg::OFFS_W-1], y_step});

  always_comb begin
    if (dec_pos) begin
      d_step = d_r + $signed({{9{diff[cor_pkg::OFFS_W]}}, diff, 2'b00}) + 24'sd10;
    end else begin
      d_step = d_r + $signed({11'b0, x_inc, 2'b00}) + 24'sd6;
    end
  end

  // the y offset can reach -1 on a zero-radius circle, so compare signed
  assign done_step = $signed({1'b0, x_inc}) > y_step;

  assign q_push = accept && (is_start || active_r);

  always_comb begin
    if (is_start) begin
      q_data.cx    = in_cx;
      q_data.cy    = in_cy;
      q_data.ox    = '0;
      q_data.oy    = {2'b00, in_radius};
      q_data.color = in_color;
      q_data.done  = 1'b0;
    end else begin
      q_data.cx    = cx_r;
      q_data.cy    = cy_r;
      q_data.ox    = {1'b0, x_inc};
      q_data.oy    = y_step;
      q_data.color = color_r;
      q_data.done  = done_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        x_r      <= '0;
        y_r      <= $signed({2'b00, in_radius});
        d_r      <= 24'sd3 - $signed({13'b0, in_radius, 1'b0});
        cx_r     <= in_cx;
        cy_r     <= in_cy;
        color_r  <= in_color;
        active_r <= 1'b1;
      end else if (active_r) begin
        x_r <= x_inc;
        y_r <= y_step;
        d_r <= d_step;
        if (done_step) begin
          active_r <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/cor_queue.sv
// two-entry step queue between front and back
`timescale 1ns / 1ps

module cor_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cor_pkg::step_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output cor_pkg::step_t  pop_data
);

  cor_pkg::step_t                 mem_r [cor_pkg::QUEUE_DEPTH];
  logic [cor_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [cor_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [cor_pkg::QCNT_W-1:0]     cnt_r;

  assign full      = (cnt_r == cor_pkg::QCNT_W'(cor_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/cor_back.sv
// back end: walks the eight octants of each step and forms pixel writes
`timescale 1ns / 1ps

module cor_back #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 768
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  cor_pkg::step_t                    q_data,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cor_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int WW    = $clog2(FRAME_WIDTH) + 2;
  localparam int IDX_W = cor_pkg::COORD_W + WW;
  localparam logic signed [IDX_W-1:0] FW_S  = IDX_W'(FRAME_WIDTH);
  localparam logic signed [IDX_W-1:0] FSIZE = IDX_W'(FRAME_WIDTH * FRAME_HEIGHT);

  localparam int CW = cor_pkg::COORD_W;

  // current step and octant counter
  cor_pkg::step_t                   cur_r;
  logic                             cur_vld_r;
  logic [cor_pkg::OCT_W-1:0]        oct_r;

  // stage 1: column and row
  logic                             s1_vld_r;
  logic signed [CW-1:0]             s1_col_r;
  logic signed [CW-1:0]             s1_row_r;
  logic [cor_pkg::COLOR_W-1:0]      s1_color_r;
  logic                             s1_last_r;
  logic                             s1_done_r;

  // stage 2: linear index
  logic                             s2_vld_r;
  logic signed [IDX_W-1:0]          s2_idx_r;
  logic [cor_pkg::COLOR_W-1:0]      s2_color_r;
  logic                             s2_last_r;
  logic                             s2_done_r;

  // output register
  logic                             out_vld_r;
  logic [cor_pkg::PIXIDX_W-1:0]     out_idx_r;
  logic                             out_we_r;
  logic [cor_pkg::COLOR_W-1:0]      out_color_r;
  logic                             out_last_r;
  logic                             out_done_r;

  logic                             adv;
  logic                             oct_end;
  logic signed [CW-1:0]             cx_e;
  logic signed [CW-1:0]             cy_e;
  logic signed [CW-1:0]             ox_e;
  logic signed [CW-1:0]             oy_e;
  logic signed [CW-1:0]             a_op;
  logic signed [CW-1:0]             b_op;
  logic signed [CW-1:0]             col_nxt;
  logic signed [CW-1:0]             row_nxt;
  logic signed [IDX_W-1:0]          row_w;
  logic signed [IDX_W-1:0]          col_w;
  logic signed [IDX_W-1:0]          idx_nxt;
  logic                             in_frame;

  // whole pipeline moves together whenever the output slot frees up
  assign adv     = !out_vld_r || out_tready;
  assign oct_end = (oct_r == cor_pkg::OCT_LAST);
  assign q_pop   = q_not_empty && (!cur_vld_r || (adv && oct_end));

  assign cx_e = $signed({cur_r.cx[cor_pkg::CENTER_W-1], cur_r.cx});
  assign cy_e = $signed({cur_r.cy[cor_pkg::CENTER_W-1], cur_r.cy});
  assign ox_e = $signed({{(CW-cor_pkg::OFFS_W){cur_r.ox[cor_pkg::OFFS_W-1]}}, cur_r.ox});
  assign oy_e = $signed({{(CW-cor_pkg::OFFS_W){cur_r.oy[cor_pkg::OFFS_W-1]}}, cur_r.oy});

  // octant bit 2 swaps the offsets, bit 0 negates column, bit 1 negates row
  assign a_op    = oct_r[2] ? oy_e : ox_e;
  assign b_op    = oct_r[2] ? ox_e : oy_e;
  assign col_nxt = oct_r[0] ? (cx_e - a_op) : (cx_e + a_op);
  assign row_nxt = oct_r[1] ? (cy_e - b_op) : (cy_e + b_op);

  assign row_w   = $signed({{(IDX_W-CW){s1_row_r[CW-1]}}, s1_row_r});
  assign col_w   = $signed({{(IDX_W-CW){s1_col_r[CW-1]}}, s1_col_r});
  assign idx_nxt = row_w * FW_S + col_w;

  assign in_frame = !s2_idx_r[IDX_W-1] && (s2_idx_r < FSIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      oct_r     <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        oct_r     <= '0;
      end else if (adv && cur_vld_r) begin
        oct_r <= oct_r + 1'b1;
        if (oct_end) begin
          cur_vld_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_vld_r  <= cur_vld_r;
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (adv) begin
      s1_col_r    <= col_nxt;
      s1_row_r    <= row_nxt;
      s1_color_r  <= cur_r.color;
      s1_last_r   <= oct_end;
      s1_done_r   <= cur_r.done;
      s2_idx_r    <= idx_nxt;
      s2_color_r  <= s1_color_r;
      s2_last_r   <= s1_last_r;
      s2_done_r   <= s1_done_r;
      out_idx_r   <= in_frame ? s2_idx_r[cor_pkg::PIXIDX_W-1:0] : '0;
      out_we_r    <= in_frame;
      out_color_r <= s2_color_r;
      out_last_r  <= s2_last_r;
      out_done_r  <= s2_done_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_color_r, out_we_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

FILE: hdl/circle_outline_rasterizer.sv
// top level of the midpoint circle outline rasterizer
//
// input beats: in_tuser selects start (0) or advance (1). a start beat latches
// center, radius and color and yields the eight writes of the first step; each
// advance beat moves one step along the octant and yields eight more writes.
// advance beats with no circle running are consumed and yield nothing.
// output beats: one pixel write each, eight per step, out_tlast on the eighth,
// out_tuser set on all writes of the circle's final step. write_enable is low
// and the index zero when the linear index falls outside the frame.
// throughput: one output beat per cycle while out_tready is high and steps wait in
// the queue, eight per step from the octant walk in the back end; a new input beat is
// taken while earlier steps are still being written, up to the two-entry step queue.
// the first write of a step passes, when the back end is idle, through the queue,
// the current step register, octant select, index multiply and output register.
// a stalled out_tready holds the output beat and the whole back pipeline; the
// front keeps taking beats until the queue fills, then drops in_tready.
// reset clears the circle state, the queue and all valid flags.
`timescale 1ns / 1ps

module circle_outline_rasterizer #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 768
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x[12:0], center_y[25:13], radius[35:26], color[67:36]
  input  logic [cor_pkg::IN_DATA_W-1:0]     in_tdata,
  // action
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_index[19:0], write_enable[20], pixel_color[52:21]
  output logic [cor_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  // circle_done
  output logic                              out_tuser
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  cor_pkg::step_t  q_wdata;
  cor_pkg::step_t  q_rdata;

  cor_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  cor_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  cor_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
